// ===== rtl/llgs_pkg.sv =====
// ----------------------------------------------------------------------------
// llgs_pkg: shared definitions for the spin Euler step block
// Default widths, register indexes, microcode word layout and the control
// store of the step program.
// ----------------------------------------------------------------------------
package llgs_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 28;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned UPC_W     = 5;

  // Request kinds on the req channel.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Reset codes in Q4.28; rescaled when the fraction width differs.
  localparam logic [63:0] ONE_Q28       = 64'd268435456;
  localparam logic [63:0] PREFACTOR_Q28 = 64'd265777686;
  localparam logic [63:0] DAMPING_Q28   = 64'd26843546;
  localparam logic [63:0] TIME_STEP_Q28 = 64'd2684355;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIELD_X   = 3'd0,
    REG_FIELD_Y   = 3'd1,
    REG_FIELD_Z   = 3'd2,
    REG_PREFACTOR = 3'd3,
    REG_DAMPING   = 3'd4,
    REG_TIME_STEP = 3'd5
  } cfg_reg_e;

  // Operand and destination selects of the datapath.
  typedef enum logic [3:0] {
    SEL_SX, SEL_SY, SEL_SZ,
    SEL_HX, SEL_HY, SEL_HZ,
    SEL_AX, SEL_AY, SEL_AZ,
    SEL_BX, SEL_BY, SEL_BZ,
    SEL_T,  SEL_DAMP, SEL_PREF, SEL_DT
  } opnd_e;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_MOV,
    ALU_ADD,
    ALU_SUB,
    ALU_LOAD
  } alu_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BR_LOAD,
    SEQ_END
  } seq_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    opnd_e             mul_a;
    opnd_e             mul_b;
    alu_e              alu;
    opnd_e             left;
    opnd_e             dst;
    seq_e              seq;
    logic [UPC_W-1:0]  target;
  } ucode_t;

  localparam logic [UPC_W-1:0] LOAD_ADDR = 5'd22;

  function automatic logic [127:0] rescale_q28(input logic [63:0] q28,
                                               input int unsigned frac);
    logic [127:0] wide;
    wide = {64'd0, q28};
    if (frac >= 28) begin
      return wide << (frac - 28);
    end
    return wide >> (28 - frac);
  endfunction

  function automatic ucode_t uw(input opnd_e a, input opnd_e b, input alu_e op,
                                input opnd_e left, input opnd_e dst, input seq_e seq);
    ucode_t w;
    w.mul_a  = a;
    w.mul_b  = b;
    w.alu    = op;
    w.left   = left;
    w.dst    = dst;
    w.seq    = seq;
    w.target = LOAD_ADDR;
    return w;
  endfunction

  // Each word issues one product and retires the product issued by the word
  // before it.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    case (addr)
      5'd0:  w = uw(SEL_SY,   SEL_HZ, ALU_NONE, SEL_T,  SEL_T,  SEQ_BR_LOAD);
      5'd1:  w = uw(SEL_SZ,   SEL_HY, ALU_MOV,  SEL_T,  SEL_T,  SEQ_NEXT);
      5'd2:  w = uw(SEL_SZ,   SEL_HX, ALU_SUB,  SEL_T,  SEL_AX, SEQ_NEXT);
      5'd3:  w = uw(SEL_SX,   SEL_HZ, ALU_MOV,  SEL_T,  SEL_T,  SEQ_NEXT);
      5'd4:  w = uw(SEL_SX,   SEL_HY, ALU_SUB,  SEL_T,  SEL_AY, SEQ_NEXT);
      5'd5:  w = uw(SEL_SY,   SEL_HX, ALU_MOV,  SEL_T,  SEL_T,  SEQ_NEXT);
      5'd6:  w = uw(SEL_SX,   SEL_AY, ALU_SUB,  SEL_T,  SEL_AZ, SEQ_NEXT);
      5'd7:  w = uw(SEL_SY,   SEL_AX, ALU_MOV,  SEL_T,  SEL_T,  SEQ_NEXT);
      5'd8:  w = uw(SEL_SY,   SEL_AZ, ALU_SUB,  SEL_T,  SEL_BZ, SEQ_NEXT);
      5'd9:  w = uw(SEL_SZ,   SEL_AY, ALU_MOV,  SEL_T,  SEL_T,  SEQ_NEXT);
      5'd10: w = uw(SEL_SZ,   SEL_AX, ALU_SUB,  SEL_T,  SEL_BX, SEQ_NEXT);
      5'd11: w = uw(SEL_SX,   SEL_AZ, ALU_MOV,  SEL_T,  SEL_T,  SEQ_NEXT);
      5'd12: w = uw(SEL_DAMP, SEL_BX, ALU_SUB,  SEL_T,  SEL_BY, SEQ_NEXT);
      5'd13: w = uw(SEL_DAMP, SEL_BY, ALU_ADD,  SEL_AX, SEL_AX, SEQ_NEXT);
      5'd14: w = uw(SEL_PREF, SEL_AX, ALU_ADD,  SEL_AY, SEL_AY, SEQ_NEXT);
      5'd15: w = uw(SEL_DAMP, SEL_BZ, ALU_MOV,  SEL_T,  SEL_AX, SEQ_NEXT);
      5'd16: w = uw(SEL_PREF, SEL_AY, ALU_ADD,  SEL_AZ, SEL_AZ, SEQ_NEXT);
      5'd17: w = uw(SEL_AX,   SEL_DT, ALU_MOV,  SEL_T,  SEL_AY, SEQ_NEXT);
      5'd18: w = uw(SEL_PREF, SEL_AZ, ALU_SUB,  SEL_SX, SEL_SX, SEQ_NEXT);
      5'd19: w = uw(SEL_AY,   SEL_DT, ALU_MOV,  SEL_T,  SEL_AZ, SEQ_NEXT);
      5'd20: w = uw(SEL_AZ,   SEL_DT, ALU_SUB,  SEL_SY, SEL_SY, SEQ_NEXT);
      5'd21: w = uw(SEL_SX,   SEL_SX, ALU_SUB,  SEL_SZ, SEL_SZ, SEQ_END);
      5'd22: w = uw(SEL_SX,   SEL_SX, ALU_LOAD, SEL_T,  SEL_SX, SEQ_END);
      default: w = uw(SEL_SX, SEL_SX, ALU_NONE, SEL_T,  SEL_T,  SEQ_END);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/llgs_req_if.sv =====
// ----------------------------------------------------------------------------
// llgs_req_if: request channel
// Carries a load or step request with the spin components to load.
// ----------------------------------------------------------------------------
interface llgs_req_if #(
  parameter int unsigned VALUE_WIDTH = llgs_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [VALUE_WIDTH-1:0] load_x;
  logic signed [VALUE_WIDTH-1:0] load_y;
  logic signed [VALUE_WIDTH-1:0] load_z;

  modport source (output valid, req_type, load_x, load_y, load_z, input ready);
  modport sink   (input valid, req_type, load_x, load_y, load_z, output ready);
endinterface

// ===== rtl/llgs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// llgs_rsp_if: result channel
// Carries the spin vector after each request.
// ----------------------------------------------------------------------------
interface llgs_rsp_if #(
  parameter int unsigned VALUE_WIDTH = llgs_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] spin_out_x;
  logic signed [VALUE_WIDTH-1:0] spin_out_y;
  logic signed [VALUE_WIDTH-1:0] spin_out_z;

  modport source (output valid, spin_out_x, spin_out_y, spin_out_z, input ready);
  modport sink   (input valid, spin_out_x, spin_out_y, spin_out_z, output ready);
endinterface

// ===== rtl/llg_spin_euler_step.sv =====
// ----------------------------------------------------------------------------
// llg_spin_euler_step: Landau-Lifshitz-Gilbert spin integrator
// Holds a spin vector and moves it one explicit Euler step per step request,
// under a small microcode program driving one shared multiplier.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the req channel and each request gives exactly
// one transfer on the rsp channel, carrying the spin vector after it. A
// request with req_type low loads the spin from load_x/y/z; with req_type
// high the block computes A = S x H, B = S x A and subtracts
// prefactor * (A + damping * B) * dt from S, all in signed fixed point with
// saturation.
// Program. A step runs 22 microcode words, one per multiplier issue, since the
// single multiplier is the only product unit and every word issues one
// product; a load runs two words. A request is taken in the idle state, runs
// its program, and in the done state its result is copied into the output
// register once that is free or being emptied.
// Stalls. The output register holds a finished result while the next request
// is accepted and computed; only if a second result is ready before the first
// has been taken does the block wait, and it takes no request meanwhile.
// Reset puts spin (1, 0, 0), field (0, 0, 1), damping, prefactor and time step
// at their default codes. The user must write configuration through cfg_we_i,
// cfg_index_i and cfg_data_i only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module llg_spin_euler_step #(
  parameter int unsigned VALUE_WIDTH = llgs_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = llgs_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [llgs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [((VALUE_WIDTH > FRAC_BITS) ? VALUE_WIDTH : FRAC_BITS + 1)-1:0]
                                               cfg_data_i,
  llgs_req_if.sink                             req,
  llgs_rsp_if.source                           rsp
);
  import llgs_pkg::*;

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned OPW = (VALUE_WIDTH > FRAC_BITS) ? VALUE_WIDTH : FRAC_BITS + 1;

  localparam logic [127:0] ONE_R  = rescale_q28(ONE_Q28, FRAC_BITS);
  localparam logic [127:0] PREF_R = rescale_q28(PREFACTOR_Q28, FRAC_BITS);
  localparam logic [127:0] DAMP_R = rescale_q28(DAMPING_Q28, FRAC_BITS);
  localparam logic [127:0] DT_R   = rescale_q28(TIME_STEP_Q28, FRAC_BITS);

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  // Configuration registers.
  logic signed [W-1:0]     field_x_q, field_y_q, field_z_q;
  logic        [W-2:0]     pref_q, damp_q;
  logic        [FRAC_BITS:0] dt_q;

  // Spin state and scratch registers of the step program.
  logic signed [W-1:0] sx_q, sy_q, sz_q;
  logic signed [W-1:0] ax_q, ay_q, az_q;
  logic signed [W-1:0] bx_q, by_q, bz_q;
  logic signed [W-1:0] t_q;

  // Request captured at the transfer.
  logic                req_type_q;
  logic signed [W-1:0] load_x_q, load_y_q, load_z_q;

  // Result register.
  logic                out_valid_q;
  logic signed [W-1:0] out_x_q, out_y_q, out_z_q;

  state_e              state_q, state_d;
  logic [UPC_W-1:0]    upc_q, upc_d;
  ucode_t              uword;

  logic                req_take;
  logic                run;
  logic                out_load;

  logic signed [OPW-1:0] src [16];
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [W-1:0]   mul_res;
  logic signed [W-1:0]   left_val;
  logic signed [W:0]     sum;
  logic signed [W-1:0]   alu_res;
  logic                  wr_en;

  assign uword    = ucode_rom(upc_q);
  assign req_take = req.valid && req.ready;

  // ---------------------------------------------------------------------------
  // Sequencer state machine.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req.valid) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (uword.seq == SEQ_END) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    run       = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: req.ready = 1'b1;
      ST_RUN:  run       = 1'b1;
      ST_DONE: out_load  = !out_valid_q || rsp.ready;
      default: ;
    endcase
  end

  // The step counter restarts at every request; the first word branches to
  // the load word when the request is a load.
  always_comb begin
    upc_d = upc_q;
    if (req_take) begin
      upc_d = '0;
    end else if (run) begin
      if (uword.seq == SEQ_BR_LOAD && req_type_q == REQ_LOAD) begin
        upc_d = uword.target;
      end else if (uword.seq != SEQ_END) begin
        upc_d = upc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      upc_q   <= '0;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_type_q <= req.req_type;
      load_x_q   <= req.load_x;
      load_y_q   <= req.load_y;
      load_z_q   <= req.load_z;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration writes. Unknown indexes are ignored.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_x_q <= '0;
      field_y_q <= '0;
      field_z_q <= ONE_R[W-1:0];
      pref_q    <= PREF_R[W-2:0];
      damp_q    <= DAMP_R[W-2:0];
      dt_q      <= DT_R[FRAC_BITS:0];
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FIELD_X:   field_x_q <= cfg_data_i[W-1:0];
        REG_FIELD_Y:   field_y_q <= cfg_data_i[W-1:0];
        REG_FIELD_Z:   field_z_q <= cfg_data_i[W-1:0];
        REG_PREFACTOR: pref_q    <= cfg_data_i[W-2:0];
        REG_DAMPING:   damp_q    <= cfg_data_i[W-2:0];
        REG_TIME_STEP: dt_q      <= cfg_data_i[FRAC_BITS:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath. Values are sign-extended to the multiplier width; the
  // coefficient registers are unsigned and zero-extended.
  // ---------------------------------------------------------------------------
  always_comb begin
    src[SEL_SX]   = OPW'(sx_q);
    src[SEL_SY]   = OPW'(sy_q);
    src[SEL_SZ]   = OPW'(sz_q);
    src[SEL_HX]   = OPW'(field_x_q);
    src[SEL_HY]   = OPW'(field_y_q);
    src[SEL_HZ]   = OPW'(field_z_q);
    src[SEL_AX]   = OPW'(ax_q);
    src[SEL_AY]   = OPW'(ay_q);
    src[SEL_AZ]   = OPW'(az_q);
    src[SEL_BX]   = OPW'(bx_q);
    src[SEL_BY]   = OPW'(by_q);
    src[SEL_BZ]   = OPW'(bz_q);
    src[SEL_T]    = OPW'(t_q);
    src[SEL_DAMP] = OPW'(damp_q);
    src[SEL_PREF] = OPW'(pref_q);
    src[SEL_DT]   = OPW'(dt_q);
  end

  assign mul_a    = src[uword.mul_a];
  assign mul_b    = src[uword.mul_b];
  assign left_val = src[uword.left][W-1:0];

  llgs_mul #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS),
    .OPW         (OPW)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  // The retired product, or its saturating sum or difference with a register.
  always_comb begin
    sum = '0;
    case (uword.alu)
      ALU_ADD: sum = {left_val[W-1], left_val} + {mul_res[W-1], mul_res};
      ALU_SUB: sum = {left_val[W-1], left_val} - {mul_res[W-1], mul_res};
      default: sum = {mul_res[W-1], mul_res};
    endcase
    if (sum[W] != sum[W-1]) begin
      alu_res = sum[W] ? VMIN : VMAX;
    end else begin
      alu_res = sum[W-1:0];
    end
  end

  assign wr_en = run && (uword.alu == ALU_MOV || uword.alu == ALU_ADD ||
                         uword.alu == ALU_SUB);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      case (uword.dst)
        SEL_AX: ax_q <= alu_res;
        SEL_AY: ay_q <= alu_res;
        SEL_AZ: az_q <= alu_res;
        SEL_BX: bx_q <= alu_res;
        SEL_BY: by_q <= alu_res;
        SEL_BZ: bz_q <= alu_res;
        SEL_T:  t_q  <= alu_res;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= ONE_R[W-1:0];
      sy_q <= '0;
      sz_q <= '0;
    end else if (run && uword.alu == ALU_LOAD) begin
      sx_q <= load_x_q;
      sy_q <= load_y_q;
      sz_q <= load_z_q;
    end else if (wr_en) begin
      case (uword.dst)
        SEL_SX: sx_q <= alu_res;
        SEL_SY: sy_q <= alu_res;
        SEL_SZ: sz_q <= alu_res;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: filled when the program has finished and the slot is
  // free or being emptied in the same cycle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q <= sx_q;
      out_y_q <= sy_q;
      out_z_q <= sz_q;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.spin_out_x = out_x_q;
  assign rsp.spin_out_y = out_y_q;
  assign rsp.spin_out_z = out_z_q;

endmodule

// ===== rtl/llgs_mul.sv =====
// ----------------------------------------------------------------------------
// llgs_mul: shared fixed-point multiplier
// Registered signed product, then arithmetic shift by the fraction width and
// saturation to the value width.
// ----------------------------------------------------------------------------
module llgs_mul #(
  parameter int unsigned VALUE_WIDTH = llgs_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = llgs_pkg::FRAC_BITS_DEF,
  parameter int unsigned OPW         = (VALUE_WIDTH > FRAC_BITS) ? VALUE_WIDTH
                                                                 : FRAC_BITS + 1
) (
  input  logic                          clk_i,
  input  logic signed [OPW-1:0]         a_i,
  input  logic signed [OPW-1:0]         b_i,
  output logic signed [VALUE_WIDTH-1:0] res_o
);
  import llgs_pkg::*;

  localparam int unsigned PW = 2 * OPW;

  logic signed [PW-1:0]            prod_d;
  logic signed [PW-1:0]            prod_q;
  logic signed [PW-1:0]            shifted;
  logic        [PW-VALUE_WIDTH:0]  upper;
  logic                            in_range;

  assign prod_d = PW'(a_i) * PW'(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign shifted  = prod_q >>> FRAC_BITS;
  assign upper    = shifted[PW-1:VALUE_WIDTH-1];
  assign in_range = (&upper) | ~(|upper);

  always_comb begin
    if (in_range) begin
      res_o = shifted[VALUE_WIDTH-1:0];
    end else if (shifted[PW-1]) begin
      res_o = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end
  end

endmodule

// ===== tb/sv/llgs_spin_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llgs_spin_checker: spin predictor and result comparison
// Watches the configuration port and both channels of the spin Euler step
// block, keeps its own copy of the spin and the registers, predicts the spin
// after every accepted request and compares it with every accepted result.
// ----------------------------------------------------------------------------
module llgs_spin_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [llgs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  llgs_req_if                            req,
  llgs_rsp_if                            rsp,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             compared_o
);
  import llgs_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;

  localparam logic signed [127:0] Q_MAX = (128'sd1 <<< (VW - 1)) - 128'sd1;
  localparam logic signed [127:0] Q_MIN = -(128'sd1 <<< (VW - 1));

  typedef logic signed [VW-1:0] q_t;
  typedef struct {
    q_t x;
    q_t y;
    q_t z;
  } spin_vec_t;

  spin_vec_t     spin_now;
  spin_vec_t     field_now;
  logic [VW-2:0] prefactor_now;
  logic [VW-2:0] damping_now;
  logic [FB:0]   dt_now;
  spin_vec_t     spin_due[$];
  int            fails;
  int            compared;

  function automatic q_t clamp_q(input logic signed [127:0] v);
    if (v > Q_MAX) return Q_MAX[VW-1:0];
    if (v < Q_MIN) return Q_MIN[VW-1:0];
    return v[VW-1:0];
  endfunction

  // Full product, floor by the fraction width, then saturation.
  function automatic q_t qmul(input logic signed [63:0] a, input logic signed [63:0] b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clamp_q((wa * wb) >>> FB);
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clamp_q(wa + wb);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clamp_q(wa - wb);
  endfunction

  function automatic spin_vec_t cross_q(input spin_vec_t u, input spin_vec_t v);
    spin_vec_t r;
    r.x = qsub(qmul(u.y, v.z), qmul(u.z, v.y));
    r.y = qsub(qmul(u.z, v.x), qmul(u.x, v.z));
    r.z = qsub(qmul(u.x, v.y), qmul(u.y, v.x));
    return r;
  endfunction

  // One component of S - pref * (A + damping * B) * dt.
  function automatic q_t damped_update(input q_t s, input q_t a, input q_t b);
    q_t c, e;
    c = qadd(a, qmul(64'(damping_now), b));
    e = qmul(qmul(64'(prefactor_now), c), 64'(dt_now));
    return qsub(s, e);
  endfunction

  function automatic spin_vec_t euler_step(input spin_vec_t s);
    spin_vec_t a, b, r;
    a   = cross_q(s, field_now);
    b   = cross_q(s, a);
    r.x = damped_update(s.x, a.x, b.x);
    r.y = damped_update(s.y, a.y, b.y);
    r.z = damped_update(s.z, a.z, b.z);
    return r;
  endfunction

  function automatic int field_mismatch(input string name, input q_t want, input q_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    spin_vec_t seen, due;
    if (!rst_ni) begin
      spin_due.delete();
      spin_now      = '{ONE_Q28[VW-1:0], q_t'(0), q_t'(0)};
      field_now     = '{q_t'(0), q_t'(0), ONE_Q28[VW-1:0]};
      prefactor_now = PREFACTOR_Q28[VW-2:0];
      damping_now   = DAMPING_Q28[VW-2:0];
      dt_now        = TIME_STEP_Q28[FB:0];
      fails         = 0;
      compared      = 0;
    end else begin
      // Results first, so that a request in the same cycle cannot cover for a
      // result that arrived with nothing waiting.
      if (rsp.valid && rsp.ready) begin
        seen = '{rsp.spin_out_x, rsp.spin_out_y, rsp.spin_out_z};
        if (spin_due.size() == 0) begin
          $error("result (%0d, %0d, %0d) with no request waiting", seen.x, seen.y, seen.z);
          fails++;
        end else begin
          due = spin_due.pop_front();
          compared++;
          fails += field_mismatch("spin_out_x", due.x, seen.x);
          fails += field_mismatch("spin_out_y", due.y, seen.y);
          fails += field_mismatch("spin_out_z", due.z, seen.z);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FIELD_X:   field_now.x   = cfg_data_i[VW-1:0];
          REG_FIELD_Y:   field_now.y   = cfg_data_i[VW-1:0];
          REG_FIELD_Z:   field_now.z   = cfg_data_i[VW-1:0];
          REG_PREFACTOR: prefactor_now = cfg_data_i[VW-2:0];
          REG_DAMPING:   damping_now   = cfg_data_i[VW-2:0];
          REG_TIME_STEP: dt_now        = cfg_data_i[FB:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_STEP) begin
          spin_now = euler_step(spin_now);
        end else begin
          spin_now = '{req.load_x, req.load_y, req.load_z};
        end
        spin_due.push_back(spin_now);
      end
    end
    fail_count_o <= fails;
    pending_o    <= spin_due.size();
    compared_o   <= compared;
  end

endmodule

// ===== tb/sv/tb_llg_spin_euler_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_llg_spin_euler_step: testbench for the spin Euler step block
// Drives load and step requests and register settings into the block, lets
// the receiver and sender idle at random, and leaves prediction and
// comparison to the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_llg_spin_euler_step;
  import llgs_pkg::*;

  localparam int unsigned VW    = VALUE_WIDTH_DEF;
  localparam int unsigned FB    = FRAC_BITS_DEF;
  localparam int unsigned CFG_W = (VW > FB) ? VW : FB + 1;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = CFG_IDX_W'(int'(REG_TIME_STEP) + 1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_1 = CFG_IDX_W'(int'(REG_TIME_STEP) + 2);

  localparam logic [VW-1:0] Q_MAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic [VW-1:0] Q_MIN = {1'b1, {(VW - 1){1'b0}}};
  localparam logic [VW-1:0] Q_ONE = ONE_Q28[VW-1:0];

  // Settle time after a drain, before touching the registers or ending the run.
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int NUM_PHASES      = 8;
  localparam int TIMEOUT_NS      = 2_000_000;

  typedef enum logic [2:0] {
    SET_RESET,
    SET_PHYSICAL,
    SET_MAX,
    SET_MIN,
    SET_RAW,
    SET_STIFF
  } reg_set_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int loads_sent;
  int steps_sent;
  int settings_applied;
  int fail_count;
  int pending;
  int compared;

  reg_set_e phase_plan [NUM_PHASES] = '{SET_RESET, SET_PHYSICAL, SET_MAX, SET_RAW,
                                        SET_MIN, SET_PHYSICAL, SET_STIFF, SET_PHYSICAL};

  llgs_req_if #(.VALUE_WIDTH(VW)) req_ch ();
  llgs_rsp_if #(.VALUE_WIDTH(VW)) rsp_ch ();

  llg_spin_euler_step #(
    .VALUE_WIDTH (VW),
    .FRAC_BITS   (FB)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  llgs_spin_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .compared_o   (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the block stops handing over results.
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still outstanding", pending);
    $display("end of test: mismatches");
    $finish;
  end

  // Receiver. Takes results at random; each new hold-off request from the
  // stimulus keeps ready low for a long stretch so that the block fills up
  // and has to refuse further requests.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // A spin component within two units either side of zero, so that runs of
  // steps follow something like a physical trajectory.
  function automatic logic [VW-1:0] near_unit();
    return VW'($urandom_range(32'h4000_0000) - 32'h2000_0000);
  endfunction

  // Offers one request and returns at the edge of its transfer, with valid
  // still high so that a following request can go out back to back.
  task automatic offer_item(input logic kind, input logic [VW-1:0] lx,
                            input logic [VW-1:0] ly, input logic [VW-1:0] lz);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.load_x   <= lx;
    req_ch.load_y   <= ly;
    req_ch.load_z   <= lz;
    do @(posedge clk_i); while (!req_ch.ready);
    if (kind == REQ_STEP) steps_sent++;
    else loads_sent++;
  endtask

  // Stops offering and waits until every predicted spin has been compared,
  // then lets the block settle. The first edge lets the checker's count
  // catch up with a transfer that happened at the edge we returned on.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
  endtask

  // Writes one whole register setting unless SET_RESET; only called while idle.
  task automatic apply_setting(input reg_set_e kind);
    logic [CFG_W-1:0] vals [6];
    case (kind)
      SET_PHYSICAL: begin
        vals[REG_FIELD_X]   = near_unit();
        vals[REG_FIELD_Y]   = near_unit();
        vals[REG_FIELD_Z]   = near_unit();
        vals[REG_PREFACTOR] = $urandom_range(32'h2000_0000);
        vals[REG_DAMPING]   = $urandom_range(32'h1000_0000);
        vals[REG_TIME_STEP] = $urandom_range(32'h0100_0000);
      end
      SET_MAX: begin
        vals[REG_FIELD_X]   = Q_MAX;
        vals[REG_FIELD_Y]   = Q_MAX;
        vals[REG_FIELD_Z]   = Q_MAX;
        vals[REG_PREFACTOR] = 32'h7fff_ffff;
        vals[REG_DAMPING]   = 32'h7fff_ffff;
        vals[REG_TIME_STEP] = 32'h1000_0000;
      end
      SET_MIN: begin
        vals[REG_FIELD_X]   = Q_MIN;
        vals[REG_FIELD_Y]   = Q_MIN;
        vals[REG_FIELD_Z]   = Q_MIN;
        vals[REG_PREFACTOR] = '0;
        vals[REG_DAMPING]   = '0;
        vals[REG_TIME_STEP] = '0;
      end
      SET_STIFF: begin
        // Strong field and the widest time step the register can hold; the
        // all-ones write also checks that bits above the width are dropped.
        vals[REG_FIELD_X]   = $urandom;
        vals[REG_FIELD_Y]   = $urandom;
        vals[REG_FIELD_Z]   = $urandom;
        vals[REG_PREFACTOR] = $urandom_range(32'h7fff_ffff, 32'h1000_0000);
        vals[REG_DAMPING]   = $urandom;
        vals[REG_TIME_STEP] = 32'hffff_ffff;
      end
      default: begin
        // Raw words, upper bits included, for every register.
        foreach (vals[i]) vals[i] = $urandom;
      end
    endcase
    if (kind != SET_RESET) begin
      foreach (vals[i]) write_reg(CFG_IDX_W'(i), vals[i]);
      if (kind == SET_RAW) begin
        write_reg(REG_SPARE_0, $urandom);
        write_reg(REG_SPARE_1, $urandom);
      end
      cfg_we <= 1'b0;
      settings_applied++;
    end
  endtask

  // Mostly a load of a plausible spin followed by a run of steps; the rest
  // are loads of arbitrary words and lone steps. Step items carry random
  // load fields, which the block must ignore.
  task automatic run_random(input int n);
    int done_items;
    int run_len;
    int roll;
    done_items = 0;
    while (done_items < n) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        offer_item(REQ_LOAD, near_unit(), near_unit(), near_unit());
        run_len = $urandom_range(12, 1);
        repeat (run_len) offer_item(REQ_STEP, $urandom, $urandom, $urandom);
        done_items += run_len + 1;
      end else if (roll < 85) begin
        offer_item(REQ_LOAD, $urandom, $urandom, $urandom);
        done_items++;
      end else begin
        offer_item(REQ_STEP, $urandom, $urandom, $urandom);
        done_items++;
      end
    end
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_LOAD;
    req_ch.load_x   <= '0;
    req_ch.load_y   <= '0;
    req_ch.load_z   <= '0;
    hold_requests    = 0;
    loads_sent       = 0;
    steps_sent       = 0;
    settings_applied = 0;
    send_idle_pct    = 15;
    recv_idle_pct   <= 49;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, under the reset registers. First a step straight from
    // the reset spin, then one whose load fields are full of noise.
    offer_item(REQ_STEP, '0, '0, '0);
    offer_item(REQ_STEP, $urandom, $urandom, $urandom);
    // A zero spin has no torque and must stay put.
    offer_item(REQ_LOAD, '0, '0, '0);
    offer_item(REQ_STEP, '0, '0, '0);
    // Extreme spins drive the cross products into saturation.
    offer_item(REQ_LOAD, Q_MAX, Q_MAX, Q_MAX);
    offer_item(REQ_STEP, '0, '0, '0);
    offer_item(REQ_LOAD, Q_MIN, Q_MIN, Q_MIN);
    offer_item(REQ_STEP, '1, '1, '1);
    offer_item(REQ_LOAD, Q_MAX, Q_MIN, '0);
    offer_item(REQ_STEP, '0, '0, '0);
    // Tiny components, where the floor of negative products matters.
    offer_item(REQ_LOAD, '1, VW'(1), '1);
    offer_item(REQ_STEP, '0, '0, '0);
    // A unit spin perpendicular to the field precesses.
    offer_item(REQ_LOAD, '0, Q_ONE, '0);
    offer_item(REQ_STEP, '0, '0, '0);
    offer_item(REQ_STEP, '0, '0, '0);
    wait_drained();

    // The receiver holds off for a long stretch while the sender keeps
    // offering steps, so that the block fills and refuses transfers.
    @(negedge clk_i);
    hold_requests++;
    @(posedge clk_i);
    repeat (10) offer_item(REQ_STEP, $urandom, $urandom, $urandom);
    wait_drained();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // Idle pattern: sender-light then receiver-light, and at the end
      // neither side idles at all.
      if (phase < 3) begin
        send_idle_pct  = 15;
        recv_idle_pct <= 49;
      end else if (phase < 6) begin
        send_idle_pct  = 49;
        recv_idle_pct <= 15;
      end else begin
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
      end
      apply_setting(phase_plan[phase]);
      run_random(ITEMS_PER_PHASE);
      wait_drained();
    end

    $display("Covered %0d loads and %0d Euler steps under %0d written register settings.",
             loads_sent, steps_sent, settings_applied);
    $display("Compared %0d results, with a long receiver hold-off and three idle patterns.",
             compared);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
